### hdl/wgg_pkg.sv
// Shared types, constants and helper functions for the waypoint go-to-goal controller.
// No dependencies; imported by wgg_cordic, wgg_ctrl, wgg_dp and the top level.
`timescale 1ns / 1ps

package wgg_pkg;

  localparam int TAB_LEN = 24;
  localparam int CNT_W   = 5;

  // Angles inside the CORDIC unit are Q.28 radians
  localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [31:0] HALFPI_Q28  = 32'sd421657428;
  localparam logic signed [31:0] INVGAIN_Q28 = 32'sd163008219;
  localparam logic signed [17:0] INVGAIN_Q16 = 18'sd39797;
  localparam logic signed [16:0] PI_Q12      = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;

  localparam logic [1:0] PH_ALIGN  = 2'd0;
  localparam logic [1:0] PH_DRIVE  = 2'd1;
  localparam logic [1:0] PH_ORIENT = 2'd2;

  localparam logic [4:0]  RST_WP_COUNT  = 5'd0;
  localparam logic [11:0] RST_ALIGN_G   = 12'd768;
  localparam logic [11:0] RST_DRIVE_G   = 12'd512;
  localparam logic [11:0] RST_ORIENT_G  = 12'd512;
  localparam logic [13:0] RST_ALIGN_TOL = 14'd41;
  localparam logic [14:0] RST_DIST_TOL  = 15'd102;
  localparam logic [13:0] RST_ORIENT_TOL = 14'd410;

  typedef enum logic [2:0] {
    CFG_WP_COUNT   = 3'd0,
    CFG_ALIGN_G    = 3'd1,
    CFG_DRIVE_G    = 3'd2,
    CFG_ORIENT_G   = 3'd3,
    CFG_ALIGN_TOL  = 3'd4,
    CFG_DIST_TOL   = 3'd5,
    CFG_ORIENT_TOL = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic       latch_pose;
    logic       ram_we;
    logic       ram_re;
    logic       vec_start;
    logic       rot_start;
    logic       dist_latch;
    logic       ang_latch;
    logic       mul1;
    logic       mul2;
    logic       out_load;
    logic [1:0] phase;
  } dp_cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic pass;
  } dp_sts_t;

  function automatic logic signed [31:0] atan_q28(input logic [CNT_W-1:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0:  r = 32'sd210828714;
      5'd1:  r = 32'sd124459457;
      5'd2:  r = 32'sd65760959;
      5'd3:  r = 32'sd33381290;
      5'd4:  r = 32'sd16755422;
      5'd5:  r = 32'sd8385879;
      5'd6:  r = 32'sd4193963;
      5'd7:  r = 32'sd2097109;
      5'd8:  r = 32'sd1048571;
      5'd9:  r = 32'sd524287;
      5'd10: r = 32'sd262144;
      5'd11: r = 32'sd131072;
      5'd12: r = 32'sd65536;
      5'd13: r = 32'sd32768;
      5'd14: r = 32'sd16384;
      5'd15: r = 32'sd8192;
      5'd16: r = 32'sd4096;
      5'd17: r = 32'sd2048;
      5'd18: r = 32'sd1024;
      5'd19: r = 32'sd512;
      5'd20: r = 32'sd256;
      5'd21: r = 32'sd128;
      5'd22: r = 32'sd64;
      5'd23: r = 32'sd32;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // Inputs stay within two turns of the range, so two correction steps suffice
  function automatic logic signed [16:0] wrap_pi(input logic signed [16:0] a);
    logic signed [16:0] r;
    r = a;
    for (int k = 0; k < 2; k++) begin
      if (r > PI_Q12) begin
        r = r - TWO_PI_Q12;
      end else if (r < -PI_Q12) begin
        r = r + TWO_PI_Q12;
      end
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -48'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### hdl/wgg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the waypoint table.
`timescale 1ns / 1ps

module wgg_ram #(
  parameter int WIDTH = 47,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/wgg_cordic.sv
// Iterative CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on wgg_pkg for the arctangent table.
`timescale 1ns / 1ps

module wgg_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               vec_i,
  input  logic signed [31:0] x0_i,
  input  logic signed [31:0] y0_i,
  input  logic signed [31:0] z0_i,
  output logic               done_o,
  output logic signed [31:0] x_o,
  output logic signed [31:0] z_o
);
  import wgg_pkg::*;

  logic signed [31:0] x_q, y_q, z_q, x_d, y_d, z_d;
  logic signed [31:0] xs, ys, a;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q, vec_q, pos, last;

  assign last = cnt_q == CNT_W'(STEPS - 1);

  always_comb begin
    xs  = x_q >>> cnt_q;
    ys  = y_q >>> cnt_q;
    a   = atan_q28(cnt_q);
    // vectoring drives y to zero, rotation drives z to zero
    pos = vec_q ? ~y_q[31] : z_q[31];
    x_d = pos ? x_q + ys : x_q - ys;
    y_d = pos ? y_q - xs : y_q + xs;
    z_d = pos ? z_q + a  : z_q - a;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x0_i;
      y_q   <= y0_i;
      z_q   <= z0_i;
      vec_q <= vec_i;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (last) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign z_o    = z_q;

endmodule

### hdl/wgg_ctrl.sv
// Controller: sequences table access, CORDIC passes, phase walk and result delivery.
// Depends on wgg_pkg for the command and status structs.
`timescale 1ns / 1ps

module wgg_ctrl #(
  parameter int MAX_WAYPOINTS = 16,
  parameter int WPW           = $clog2(MAX_WAYPOINTS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              func_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic [4:0]        waypoint_count_i,
  input  wgg_pkg::dp_sts_t  sts_i,
  output wgg_pkg::dp_cmd_t  cmd_o,
  output logic [WPW-1:0]    wp_o
);
  import wgg_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHECK = 10'b0000000010,
    S_FETCH = 10'b0000000100,
    S_VEC   = 10'b0000001000,
    S_DIST  = 10'b0000010000,
    S_EVAL  = 10'b0000100000,
    S_ROT   = 10'b0001000000,
    S_MUL1  = 10'b0010000000,
    S_MUL2  = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_e;

  state_e         state_q, state_d;
  logic [WPW-1:0] wp_q, wp_d;
  logic [1:0]     phase_q, phase_d;
  logic           out_valid_q, out_valid_d;
  logic [8:0]     limit;
  logic           list_end;

  always_comb begin
    limit = (9'(waypoint_count_i) < 9'(MAX_WAYPOINTS)) ? 9'(waypoint_count_i)
                                                       : 9'(MAX_WAYPOINTS);
    list_end = 9'(wp_q) >= limit;
  end

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.phase = phase_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (func_i) begin
            cmd_o.ram_we = 1'b1;
          end else begin
            cmd_o.latch_pose = 1'b1;
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (list_end) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.ram_re = 1'b1;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.vec_start = 1'b1;
        state_d = S_VEC;
      end
      S_VEC: begin
        if (sts_i.cordic_done) begin
          state_d = S_DIST;
        end
      end
      S_DIST: begin
        cmd_o.dist_latch = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        // a phase that passes hands the same sample to the next phase
        unique case (phase_q)
          PH_ALIGN: begin
            if (sts_i.pass) begin
              phase_d = PH_DRIVE;
            end else begin
              cmd_o.ang_latch = 1'b1;
              state_d = S_EMIT;
            end
          end
          PH_DRIVE: begin
            if (sts_i.pass) begin
              phase_d = PH_ORIENT;
            end else begin
              cmd_o.rot_start = 1'b1;
              state_d = S_ROT;
            end
          end
          default: begin
            if (sts_i.pass) begin
              phase_d = PH_ALIGN;
              wp_d    = wp_q + WPW'(1);
              state_d = S_CHECK;
            end else begin
              cmd_o.ang_latch = 1'b1;
              state_d = S_EMIT;
            end
          end
        endcase
      end
      S_ROT: begin
        if (sts_i.cordic_done) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      phase_q     <= PH_ALIGN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign wp_o        = wp_q;

endmodule

### hdl/wgg_dp.sv
// Datapath: waypoint table, pose latch, CORDIC setup, error and command arithmetic,
// output payload registers. Depends on wgg_pkg, wgg_ram and wgg_cordic.
`timescale 1ns / 1ps

module wgg_dp #(
  parameter int MAX_WAYPOINTS = 16,
  parameter int CORDIC_STEPS  = 16,
  parameter int WPW           = $clog2(MAX_WAYPOINTS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wgg_pkg::dp_cmd_t   cmd_i,
  output wgg_pkg::dp_sts_t   sts_o,
  input  logic [WPW-1:0]     wp_i,
  input  logic signed [15:0] pose_x_i,
  input  logic signed [15:0] pose_y_i,
  input  logic signed [14:0] pose_heading_i,
  input  logic [3:0]         slot_i,
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  input  logic signed [14:0] goal_heading_i,
  input  logic [11:0]        align_gain_i,
  input  logic [11:0]        drive_gain_i,
  input  logic [11:0]        orient_gain_i,
  input  logic [13:0]        align_tol_i,
  input  logic [14:0]        dist_tol_i,
  input  logic [13:0]        orient_tol_i,
  output logic signed [15:0] linear_cmd_o,
  output logic signed [15:0] angular_cmd_o,
  output logic [3:0]         waypoint_index_o,
  output logic [1:0]         phase_o
);
  import wgg_pkg::*;

  localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

  logic signed [15:0] px_q, py_q, gx, gy;
  logic signed [14:0] ph_q, gh;
  logic [46:0]        rdata;
  logic [8:0]         slot_ext, wp_ext;
  logic               slot_ok;

  assign slot_ext = 9'(slot_i);
  assign wp_ext   = 9'(wp_i);
  assign slot_ok  = slot_ext < 9'(MAX_WAYPOINTS);

  wgg_ram #(
    .WIDTH(47),
    .DEPTH(MAX_WAYPOINTS),
    .AW   (AW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ram_we && slot_ok),
    .waddr_i(slot_ext[AW-1:0]),
    .wdata_i({goal_x_i, goal_y_i, goal_heading_i}),
    .re_i   (cmd_i.ram_re),
    .raddr_i(wp_ext[AW-1:0]),
    .rdata_o(rdata)
  );

  assign gx = rdata[46:31];
  assign gy = rdata[30:15];
  assign gh = rdata[14:0];

  // vectoring setup, left half plane folded over by pi
  logic signed [16:0] dx, dy;
  logic signed [31:0] xv, yv, vx0, vy0, vz0;
  logic               zero_q;

  always_comb begin
    dx = 17'(gx) - 17'(px_q);
    dy = 17'(gy) - 17'(py_q);
    xv = 32'(dx) <<< 12;
    yv = 32'(dy) <<< 12;
    if (xv < 0) begin
      vx0 = -xv;
      vy0 = -yv;
      vz0 = (yv >= 0) ? PI_Q28 : -PI_Q28;
    end else begin
      vx0 = xv;
      vy0 = yv;
      vz0 = '0;
    end
  end

  // error terms
  logic signed [16:0] dir_q, err0, err2, err_sel;
  logic [16:0]        err_abs;
  logic [13:0]        tol_sel;
  logic [11:0]        gain_sel;
  logic signed [48:0] dprod_q, dprod_d, dround;
  logic [17:0]        dist_val;
  logic signed [29:0] aprod;
  logic signed [20:0] around;
  logic signed [15:0] ang_val;

  always_comb begin
    err0     = wrap_pi(dir_q - 17'(ph_q));
    err2     = wrap_pi(17'(gh) - 17'(ph_q));
    err_sel  = (cmd_i.phase == PH_ORIENT) ? err2 : err0;
    tol_sel  = (cmd_i.phase == PH_ORIENT) ? orient_tol_i : align_tol_i;
    gain_sel = (cmd_i.phase == PH_ORIENT) ? orient_gain_i : align_gain_i;
    err_abs  = err_sel[16] ? 17'(-err_sel) : 17'(err_sel);
    dround   = (dprod_q + 49'sd134217728) >>> 28;
    dist_val = dround[17:0];
    aprod    = $signed({1'b0, gain_sel}) * err_sel;
    around   = 21'((aprod + 30'sd512) >>> 10);
    ang_val  = sat16(48'(around));
  end

  assign sts_o.pass = (cmd_i.phase == PH_DRIVE) ? (dist_val < 18'(dist_tol_i))
                                                : (err_abs < 17'(tol_sel));

  // rotation setup for cos, folded into +-pi/2
  logic signed [31:0] zt, rz0, cx, cz, x0, y0, z0, ct, zr;
  logic               rneg, neg_q, cdone;

  always_comb begin
    zt = 32'(err0) <<< 16;
    if (zt > HALFPI_Q28) begin
      rz0  = zt - PI_Q28;
      rneg = 1'b1;
    end else if (zt < -HALFPI_Q28) begin
      rz0  = zt + PI_Q28;
      rneg = 1'b1;
    end else begin
      rz0  = zt;
      rneg = 1'b0;
    end
    x0 = cmd_i.vec_start ? vx0 : INVGAIN_Q28;
    y0 = cmd_i.vec_start ? vy0 : 32'sd0;
    z0 = cmd_i.vec_start ? vz0 : rz0;
  end

  wgg_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.vec_start || cmd_i.rot_start),
    .vec_i  (cmd_i.vec_start),
    .x0_i   (x0),
    .y0_i   (y0),
    .z0_i   (z0),
    .done_o (cdone),
    .x_o    (cx),
    .z_o    (cz)
  );

  assign sts_o.cordic_done = cdone;

  // cos in Q1.14 and the drive command products
  logic signed [15:0] cc, c_q, c_d, lin_val;
  logic [29:0]        p1_q;
  logic signed [46:0] lprod, lround;

  always_comb begin
    zr      = (cz + 32'sd32768) >>> 16;
    dprod_d = cx * INVGAIN_Q16;
    ct      = (cx + 32'sd8192) >>> 14;
    if (ct > 32'sd16384) begin
      cc = 16'sd16384;
    end else if (ct < -32'sd16384) begin
      cc = -16'sd16384;
    end else begin
      cc = ct[15:0];
    end
    c_d     = neg_q ? -cc : cc;
    lprod   = $signed({1'b0, p1_q}) * c_q;
    lround  = (lprod + 47'sd2097152) >>> 22;
    lin_val = sat16(48'(lround));
  end

  logic signed [15:0] lin_q, ang_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_pose) begin
      px_q <= pose_x_i;
      py_q <= pose_y_i;
      ph_q <= pose_heading_i;
    end
    if (cmd_i.vec_start) begin
      zero_q <= (dx == 17'sd0) && (dy == 17'sd0);
    end
    if (cmd_i.rot_start) begin
      neg_q <= rneg;
    end
    if (cmd_i.dist_latch) begin
      // goal on the pose: angle and distance are both zero
      dir_q   <= zero_q ? 17'sd0 : zr[16:0];
      dprod_q <= zero_q ? 49'sd0 : dprod_d;
    end
    if (cmd_i.ang_latch) begin
      lin_q <= '0;
      ang_q <= ang_val;
    end
    if (cmd_i.mul1) begin
      p1_q <= 30'(drive_gain_i) * 30'(dist_val);
      c_q  <= c_d;
    end
    if (cmd_i.mul2) begin
      lin_q <= lin_val;
      ang_q <= '0;
    end
    if (cmd_i.out_load) begin
      linear_cmd_o     <= lin_q;
      angular_cmd_o    <= ang_q;
      waypoint_index_o <= 4'(wp_i);
      phase_o          <= cmd_i.phase;
    end
  end

endmodule

### hdl/waypoint_go_to_goal_controller.sv
// Waypoint go-to-goal controller, top level: configuration registers, controller
// and datapath. Depends on wgg_pkg, wgg_ctrl and wgg_dp.
//
// One item is worked on at a time. A load item writes one table slot. A pose sample
// returns to idle without a result when the list has ended; each waypoint it visits
// takes a table read, a vectoring pass and the distance product, then a check of
// the phases in turn from the held phase; a drive command adds the cosine pass
// and its two products before the command is issued. The iterative CORDIC unit
// does one micro-rotation per cycle. A finished result waits in the output
// register while the next item is taken.
`timescale 1ns / 1ps

module waypoint_go_to_goal_controller #(
  parameter int MAX_WAYPOINTS = 16,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic signed [15:0] pose_x_i,
  input  logic signed [15:0] pose_y_i,
  input  logic signed [14:0] pose_heading_i,
  input  logic [3:0]         slot_i,
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  input  logic signed [14:0] goal_heading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] linear_cmd_o,
  output logic signed [15:0] angular_cmd_o,
  output logic [3:0]         waypoint_index_o,
  output logic [1:0]         phase_o
);
  import wgg_pkg::*;

  localparam int WPW = $clog2(MAX_WAYPOINTS + 1);

  logic [4:0]  wp_count_q;
  logic [11:0] align_g_q, drive_g_q, orient_g_q;
  logic [13:0] align_tol_q, orient_tol_q;
  logic [14:0] dist_tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_count_q   <= RST_WP_COUNT;
      align_g_q    <= RST_ALIGN_G;
      drive_g_q    <= RST_DRIVE_G;
      orient_g_q   <= RST_ORIENT_G;
      align_tol_q  <= RST_ALIGN_TOL;
      dist_tol_q   <= RST_DIST_TOL;
      orient_tol_q <= RST_ORIENT_TOL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WP_COUNT:   wp_count_q   <= cfg_data_i[4:0];
        CFG_ALIGN_G:    align_g_q    <= cfg_data_i[11:0];
        CFG_DRIVE_G:    drive_g_q    <= cfg_data_i[11:0];
        CFG_ORIENT_G:   orient_g_q   <= cfg_data_i[11:0];
        CFG_ALIGN_TOL:  align_tol_q  <= cfg_data_i[13:0];
        CFG_DIST_TOL:   dist_tol_q   <= cfg_data_i;
        CFG_ORIENT_TOL: orient_tol_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t        cmd;
  dp_sts_t        sts;
  logic [WPW-1:0] wp;

  wgg_ctrl #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS),
    .WPW          (WPW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .func_i          (func_i),
    .in_stall_o      (in_stall_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .waypoint_count_i(wp_count_q),
    .sts_i           (sts),
    .cmd_o           (cmd),
    .wp_o            (wp)
  );

  wgg_dp #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS),
    .CORDIC_STEPS (CORDIC_STEPS),
    .WPW          (WPW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .wp_i            (wp),
    .pose_x_i        (pose_x_i),
    .pose_y_i        (pose_y_i),
    .pose_heading_i  (pose_heading_i),
    .slot_i          (slot_i),
    .goal_x_i        (goal_x_i),
    .goal_y_i        (goal_y_i),
    .goal_heading_i  (goal_heading_i),
    .align_gain_i    (align_g_q),
    .drive_gain_i    (drive_g_q),
    .orient_gain_i   (orient_g_q),
    .align_tol_i     (align_tol_q),
    .dist_tol_i      (dist_tol_q),
    .orient_tol_i    (orient_tol_q),
    .linear_cmd_o    (linear_cmd_o),
    .angular_cmd_o   (angular_cmd_o),
    .waypoint_index_o(waypoint_index_o),
    .phase_o         (phase_o)
  );

`ifndef SYNTHESIS
  // only the drive phase commands forward motion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (phase_o != PH_DRIVE) |-> linear_cmd_o == 16'sd0)
    else $error("linear command outside drive phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (phase_o == PH_DRIVE) |-> angular_cmd_o == 16'sd0)
    else $error("angular command in drive phase");

  // an accepted pose sample always makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !func_i |=> in_stall_o)
    else $error("sample accepted without going busy");

  // a new result never lands on one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(linear_cmd_o) && $stable(angular_cmd_o))
    else $error("held result overwritten");
`endif

endmodule
